// ===== hdl/apca_pkg.sv =====
package apca_pkg;

  localparam int NUM_RES   = 16;
  localparam int NUM_SLOTS = 16;
  localparam int SCAN_CYCLES = NUM_SLOTS + 4;

  localparam logic [2:0] KIND_ENQUEUE  = 3'd0;
  localparam logic [2:0] KIND_POLL     = 3'd1;
  localparam logic [2:0] KIND_ABANDON  = 3'd2;
  localparam logic [2:0] KIND_RELEASE  = 3'd3;
  localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_GRANTED_NOW = 3'd1;
  localparam logic [2:0] ST_QUEUED      = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_ABORTED     = 3'd4;
  localparam logic [2:0] ST_NO_SPACE    = 3'd5;

  localparam logic [1:0] WS_QUEUED    = 2'd0;
  localparam logic [1:0] WS_GRANTED   = 2'd1;
  localparam logic [1:0] WS_CLAIMED   = 2'd2;
  localparam logic [1:0] WS_CANCELLED = 2'd3;

  localparam logic [16:0] PEND_LIMIT_MAX = 17'd65536;
  localparam logic [31:0] AGE_SAT_MS     = 32'd256000;
  localparam logic [18:0] MS_RECIP       = 19'd268436;
  localparam int          RECIP_SHIFT    = 28;
  localparam logic [7:0]  RANK_MAX       = 8'd255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  resource;
    logic [3:0]  slot;
    logic [7:0]  capacity;
    logic [16:0] pend_limit;
    logic [7:0]  priority_req;
    logic [7:0]  weight;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] waiter_slot;
    logic [1:0] waiter_state;
    logic       grant_valid;
    logic [3:0] grant_slot;
  } resp_t;

  typedef struct packed {
    logic alloc;
    logic set_granted;
    logic cancel;
    logic free;
    logic cancel_queued;
  } cell_cmd_t;

  typedef struct packed {
    logic [3:0]  resource;
    logic [7:0]  prio;
    logic [7:0]  weight;
    logic [63:0] seq;
    logic [31:0] now_ms;
  } alloc_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  rank;
    logic [63:0] seq;
    logic [3:0]  idx;
  } scan_t;

  typedef struct packed {
    logic       used;
    logic [1:0] state;
    logic [3:0] resource;
  } cell_view_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SEND} ctrl_state_t;

endpackage

// ===== hdl/apca_cell.sv =====
module apca_cell #(
  parameter logic [3:0] IDX = 4'd0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  apca_pkg::cell_cmd_t   cmd,
  input  apca_pkg::alloc_t      alloc,
  input  logic [31:0]           scan_now,
  input  logic [3:0]            scan_res,
  input  apca_pkg::scan_t       carry_in,
  output apca_pkg::scan_t       carry_out,
  output apca_pkg::cell_view_t  view
);

  logic        used;
  logic [1:0]  state;
  logic [3:0]  res;
  logic [7:0]  prio;
  logic [7:0]  wt;
  logic [63:0] seq;
  logic [31:0] sub;

  logic [31:0] elapsed;
  logic        age_big;
  logic [7:0]  age_q;
  logic [7:0]  rank;
  logic [36:0] prod;
  logic [16:0] score;
  logic        elig;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (cmd.alloc) begin
      used <= 1'b1;
    end else if (cmd.free) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      state <= apca_pkg::WS_QUEUED;
      res   <= alloc.resource;
      prio  <= alloc.prio;
      wt    <= alloc.weight;
      seq   <= alloc.seq;
      sub   <= alloc.now_ms;
    end else if (cmd.set_granted) begin
      state <= apca_pkg::WS_GRANTED;
    end else if (cmd.cancel) begin
      state <= apca_pkg::WS_CANCELLED;
    end else if (cmd.cancel_queued && state == apca_pkg::WS_QUEUED) begin
      state <= apca_pkg::WS_CANCELLED;
    end
  end

  // aged rank, three stages
  assign prod  = 37'(elapsed[17:0]) * 37'(apca_pkg::MS_RECIP);
  assign score = 17'(prio) + 17'(age_q) * 17'(wt);

  always_ff @(posedge clk) begin
    elapsed <= (scan_now > sub) ? scan_now - sub : 32'd0;
    age_big <= elapsed >= apca_pkg::AGE_SAT_MS;
    age_q   <= prod[apca_pkg::RECIP_SHIFT +: 8];
    rank    <= (age_big || score > 17'(apca_pkg::RANK_MAX)) ? apca_pkg::RANK_MAX
                                                             : score[7:0];
  end

  assign elig = used && state == apca_pkg::WS_QUEUED && res == scan_res;
  assign take = !carry_in.found || rank > carry_in.rank ||
                (rank == carry_in.rank && seq < carry_in.seq);

  always_ff @(posedge clk) begin
    if (elig && take) begin
      carry_out <= '{found: 1'b1, rank: rank, seq: seq, idx: IDX};
    end else begin
      carry_out <= carry_in;
    end
  end

  assign view = '{used: used, state: state, resource: res};

endmodule

// ===== hdl/aging_priority_capacity_arbiter.sv =====
// Capacity arbiter for 16 resources with 16 waiter slots, one request at a time.
// Enqueue, poll, shutdown, and a release or abandon that cannot grant a queued
// waiter load their result into the output register at the accepting edge, so it
// can be taken in the cycle after acceptance. A release or abandon that may grant
// a queued waiter goes through the scan and send states: the waiter cells compute
// their aged rank in a three-stage pipeline, the best candidate then ripples
// through the row of 16 cells, one cell per cycle, and the grant is applied at
// the end of the scan before the result is registered from the send state. A new
// request is accepted only when no other request is in progress and no result
// waits, or the waiting result is taken in the same cycle.
module aging_priority_capacity_arbiter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  apca_pkg::req_t    req,
  output logic              resp_valid,
  input  logic              resp_stall,
  output apca_pkg::resp_t   resp
);

  logic [7:0]  res_cap  [apca_pkg::NUM_RES];
  logic [7:0]  res_act  [apca_pkg::NUM_RES];
  logic [4:0]  res_wait [apca_pkg::NUM_RES];
  logic [7:0]  res_cap_next  [apca_pkg::NUM_RES];
  logic [7:0]  res_act_next  [apca_pkg::NUM_RES];
  logic [4:0]  res_wait_next [apca_pkg::NUM_RES];
  logic [63:0] next_seq, next_seq_next;
  logic        stopping, stopping_next;
  apca_pkg::ctrl_state_t state, state_next;
  logic [4:0]  cnt, cnt_next;
  logic [31:0] scan_now, scan_now_next;
  logic [3:0]  scan_res, scan_res_next;
  apca_pkg::resp_t pend, pend_next;
  apca_pkg::resp_t resp_next;
  logic        resp_valid_next;

  apca_pkg::cell_cmd_t  cmd   [apca_pkg::NUM_SLOTS];
  apca_pkg::cell_view_t view  [apca_pkg::NUM_SLOTS];
  apca_pkg::scan_t      chain [apca_pkg::NUM_SLOTS + 1];
  apca_pkg::alloc_t     alloc;

  logic        take;
  logic        free_found;
  logic [3:0]  free_idx;
  logic        rel;
  logic [3:0]  rel_res;
  logic [3:0]  r;
  logic [7:0]  act_m1;
  apca_pkg::resp_t rv;
  apca_pkg::cell_view_t sv;

  assign chain[0] = '0;

  for (genvar i = 0; i < apca_pkg::NUM_SLOTS; i++) begin : g_cell
    apca_cell #(.IDX(4'(i))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd[i]),
      .alloc     (alloc),
      .scan_now  (scan_now),
      .scan_res  (scan_res),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .view      (view[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < apca_pkg::NUM_RES; i++) begin
        res_cap[i]  <= '0;
        res_act[i]  <= '0;
        res_wait[i] <= '0;
      end
      next_seq   <= 64'd1;
      stopping   <= 1'b0;
      state      <= apca_pkg::S_IDLE;
      resp_valid <= 1'b0;
    end else begin
      res_cap    <= res_cap_next;
      res_act    <= res_act_next;
      res_wait   <= res_wait_next;
      next_seq   <= next_seq_next;
      stopping   <= stopping_next;
      state      <= state_next;
      resp_valid <= resp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    scan_now <= scan_now_next;
    scan_res <= scan_res_next;
    pend     <= pend_next;
    resp     <= resp_next;
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = apca_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!view[i].used) begin
        free_found = 1'b1;
        free_idx   = 4'(i);
      end
    end
  end

  assign take      = state == apca_pkg::S_IDLE && (!resp_valid || !resp_stall);
  assign req_stall = !take;
  assign r         = req.resource;
  assign sv        = view[req.slot];

  assign alloc = '{resource: req.resource, prio: req.priority_req,
                   weight: (req.weight == 8'd0) ? 8'd1 : req.weight,
                   seq: next_seq, now_ms: req.now_ms};

  always_comb begin
    res_cap_next    = res_cap;
    res_act_next    = res_act;
    res_wait_next   = res_wait;
    next_seq_next   = next_seq;
    stopping_next   = stopping;
    state_next      = state;
    cnt_next        = cnt;
    scan_now_next   = scan_now;
    scan_res_next   = scan_res;
    pend_next       = pend;
    resp_next       = resp;
    resp_valid_next = resp_valid && resp_stall;
    for (int i = 0; i < apca_pkg::NUM_SLOTS; i++) begin
      cmd[i] = '0;
    end
    rv      = '0;
    rel     = 1'b0;
    rel_res = r;
    act_m1  = '0;

    case (state)
      apca_pkg::S_IDLE: begin
        if (req_valid && take) begin
          case (req.kind)
            apca_pkg::KIND_ENQUEUE: begin
              if (req.capacity == 8'd0 || req.pend_limit == 17'd0 ||
                  req.pend_limit > apca_pkg::PEND_LIMIT_MAX) begin
                rv.status = apca_pkg::ST_INVALID;
              end else if (stopping) begin
                rv.status = apca_pkg::ST_ABORTED;
              end else if (res_cap[r] != 8'd0 && res_cap[r] != req.capacity) begin
                rv.status = apca_pkg::ST_INVALID;
              end else begin
                res_cap_next[r] = req.capacity;
                if (res_act[r] < req.capacity && res_wait[r] == 5'd0) begin
                  res_act_next[r] = res_act[r] + 8'd1;
                  rv.status = apca_pkg::ST_GRANTED_NOW;
                end else if (17'(res_wait[r]) >= req.pend_limit || !free_found) begin
                  rv.status = apca_pkg::ST_NO_SPACE;
                end else begin
                  cmd[free_idx].alloc = 1'b1;
                  next_seq_next    = next_seq + 64'd1;
                  res_wait_next[r] = res_wait[r] + 5'd1;
                  rv.status        = apca_pkg::ST_QUEUED;
                  rv.waiter_slot   = free_idx;
                  rv.waiter_state  = apca_pkg::WS_QUEUED;
                end
              end
            end
            apca_pkg::KIND_POLL: begin
              if (!sv.used) begin
                rv.status = apca_pkg::ST_INVALID;
              end else begin
                rv.waiter_slot = req.slot;
                if (sv.state == apca_pkg::WS_GRANTED) begin
                  cmd[req.slot].free = 1'b1;
                  rv.waiter_state = apca_pkg::WS_CLAIMED;
                end else if (sv.state == apca_pkg::WS_QUEUED) begin
                  rv.waiter_state = apca_pkg::WS_QUEUED;
                end else begin
                  cmd[req.slot].free = 1'b1;
                  rv.status       = apca_pkg::ST_ABORTED;
                  rv.waiter_state = apca_pkg::WS_CANCELLED;
                end
              end
            end
            apca_pkg::KIND_ABANDON: begin
              if (!sv.used) begin
                rv.status = apca_pkg::ST_INVALID;
              end else begin
                rv.waiter_slot  = req.slot;
                rv.waiter_state = apca_pkg::WS_CANCELLED;
                cmd[req.slot].cancel = 1'b1;
                cmd[req.slot].free   = 1'b1;
                if (sv.state == apca_pkg::WS_QUEUED) begin
                  if (res_wait[sv.resource] != 5'd0) begin
                    res_wait_next[sv.resource] = res_wait[sv.resource] - 5'd1;
                  end
                end else if (sv.state == apca_pkg::WS_GRANTED) begin
                  rel     = 1'b1;
                  rel_res = sv.resource;
                end
              end
            end
            apca_pkg::KIND_RELEASE: begin
              rel = 1'b1;
            end
            apca_pkg::KIND_SHUTDOWN: begin
              if (!stopping) begin
                stopping_next = 1'b1;
                for (int i = 0; i < apca_pkg::NUM_SLOTS; i++) begin
                  cmd[i].cancel_queued = 1'b1;
                end
                for (int i = 0; i < apca_pkg::NUM_RES; i++) begin
                  res_wait_next[i] = '0;
                end
              end
            end
            default: begin
              rv.status = apca_pkg::ST_INVALID;
            end
          endcase

          act_m1 = res_act[rel_res] - 8'd1;
          if (rel && res_cap[rel_res] != 8'd0 && res_act[rel_res] != 8'd0 &&
              !stopping && act_m1 < res_cap[rel_res] && res_wait[rel_res] != 5'd0) begin
            res_act_next[rel_res] = act_m1;
            pend_next     = rv;
            scan_res_next = rel_res;
            scan_now_next = req.now_ms;
            cnt_next      = '0;
            state_next    = apca_pkg::S_SCAN;
          end else begin
            if (rel && res_cap[rel_res] != 8'd0 && res_act[rel_res] != 8'd0) begin
              res_act_next[rel_res] = act_m1;
            end
            resp_next       = rv;
            resp_valid_next = 1'b1;
          end
        end
      end
      apca_pkg::S_SCAN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(apca_pkg::SCAN_CYCLES - 1)) begin
          if (chain[apca_pkg::NUM_SLOTS].found) begin
            cmd[chain[apca_pkg::NUM_SLOTS].idx].set_granted = 1'b1;
            res_wait_next[scan_res] = res_wait[scan_res] - 5'd1;
            res_act_next[scan_res]  = res_act[scan_res] + 8'd1;
            pend_next.grant_valid   = 1'b1;
            pend_next.grant_slot    = chain[apca_pkg::NUM_SLOTS].idx;
          end
          state_next = apca_pkg::S_SEND;
        end
      end
      apca_pkg::S_SEND: begin
        if (!resp_valid || !resp_stall) begin
          resp_next       = pend;
          resp_valid_next = 1'b1;
          state_next      = apca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = apca_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/apca_checker.sv =====
module apca_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input apca_pkg::req_t  req,
  input logic            resp_valid,
  input logic            resp_stall,
  input apca_pkg::resp_t resp
);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid && $stable(resp))
    else $error("result dropped while stalled");

  a_grant_done: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.grant_valid |-> resp.status == apca_pkg::ST_DONE)
    else $error("grant with non-done status");

  a_grant_slot_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp.grant_valid |-> resp.grant_slot == 4'd0)
    else $error("grant slot set without grant");

  a_queued_state: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status == apca_pkg::ST_QUEUED |->
      resp.waiter_state == apca_pkg::WS_QUEUED && !resp.grant_valid)
    else $error("queued request carries bad state");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status == apca_pkg::ST_INVALID |->
      resp.waiter_slot == 4'd0 && resp.waiter_state == 2'd0)
    else $error("invalid request carries slot data");

endmodule

bind aging_priority_capacity_arbiter apca_checker u_apca_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int KIND_UNKNOWN = 7;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_stall;
  apca_pkg::req_t  req;
  logic            resp_valid;
  logic            resp_stall;
  apca_pkg::resp_t resp;

  aging_priority_capacity_arbiter dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .resp_valid(resp_valid), .resp_stall(resp_stall), .resp(resp)
  );

  // arbiter state mirror
  logic [7:0]  cap_tbl [apca_pkg::NUM_RES];
  logic [7:0]  active_tbl [apca_pkg::NUM_RES];
  logic [4:0]  waiting_tbl [apca_pkg::NUM_RES];
  logic        used_tbl [apca_pkg::NUM_SLOTS];
  logic [1:0]  wstate_tbl [apca_pkg::NUM_SLOTS];
  logic [3:0]  wres_tbl [apca_pkg::NUM_SLOTS];
  logic [7:0]  wprio_tbl [apca_pkg::NUM_SLOTS];
  logic [7:0]  wweight_tbl [apca_pkg::NUM_SLOTS];
  logic [63:0] wseq_tbl [apca_pkg::NUM_SLOTS];
  logic [31:0] wsubmit_tbl [apca_pkg::NUM_SLOTS];
  logic [63:0] seq_next;
  logic        shutting;

  apca_pkg::resp_t pending_resp [$];
  int          mismatches;
  int          resp_count;
  int          grant_count;
  int          req_count;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] aged_rank(int s, logic [31:0] now);
    logic [63:0] elapsed;
    logic [63:0] score;
    elapsed = (now > wsubmit_tbl[s]) ? 64'(now - wsubmit_tbl[s]) : 64'd0;
    score = 64'(wprio_tbl[s]) + (elapsed / 64'd1000) * 64'(wweight_tbl[s]);
    return (score > 64'd255) ? apca_pkg::RANK_MAX : score[7:0];
  endfunction

  function automatic int release_unit(logic [3:0] r, logic [31:0] now);
    int best;
    logic [7:0] best_rank;
    logic [7:0] rk;
    best = -1;
    best_rank = '0;
    if (cap_tbl[r] == 8'd0 || active_tbl[r] == 8'd0) return -1;
    active_tbl[r]--;
    if (shutting || active_tbl[r] >= cap_tbl[r] || waiting_tbl[r] == 5'd0) return -1;
    for (int s = 0; s < apca_pkg::NUM_SLOTS; s++) begin
      if (!used_tbl[s] || wstate_tbl[s] != apca_pkg::WS_QUEUED || wres_tbl[s] != r)
        continue;
      rk = aged_rank(s, now);
      if (best < 0 || rk > best_rank ||
          (rk == best_rank && wseq_tbl[s] < wseq_tbl[best])) begin
        best = s;
        best_rank = rk;
      end
    end
    if (best < 0) return -1;
    wstate_tbl[best] = apca_pkg::WS_GRANTED;
    waiting_tbl[r]--;
    active_tbl[r]++;
    return best;
  endfunction

  function automatic apca_pkg::resp_t arbitrate(apca_pkg::req_t q);
    apca_pkg::resp_t o;
    int g;
    logic [1:0] st;
    o = '0;
    g = -1;
    case (q.kind)
      apca_pkg::KIND_ENQUEUE: begin
        if (q.capacity == 8'd0 || q.pend_limit == 17'd0 ||
            q.pend_limit > apca_pkg::PEND_LIMIT_MAX)
          o.status = apca_pkg::ST_INVALID;
        else if (shutting)
          o.status = apca_pkg::ST_ABORTED;
        else if (cap_tbl[q.resource] != 8'd0 && cap_tbl[q.resource] != q.capacity)
          o.status = apca_pkg::ST_INVALID;
        else begin
          cap_tbl[q.resource] = q.capacity;
          if (active_tbl[q.resource] < q.capacity && waiting_tbl[q.resource] == 5'd0) begin
            active_tbl[q.resource]++;
            o.status = apca_pkg::ST_GRANTED_NOW;
          end else if (17'(waiting_tbl[q.resource]) >= q.pend_limit) begin
            o.status = apca_pkg::ST_NO_SPACE;
          end else begin
            o.status = apca_pkg::ST_NO_SPACE;
            for (int s = 0; s < apca_pkg::NUM_SLOTS; s++) begin
              if (used_tbl[s]) continue;
              used_tbl[s] = 1'b1;
              wstate_tbl[s] = apca_pkg::WS_QUEUED;
              wres_tbl[s] = q.resource;
              wprio_tbl[s] = q.priority_req;
              wweight_tbl[s] = (q.weight == 8'd0) ? 8'd1 : q.weight;
              wseq_tbl[s] = seq_next;
              seq_next++;
              wsubmit_tbl[s] = q.now_ms;
              waiting_tbl[q.resource]++;
              o.status = apca_pkg::ST_QUEUED;
              o.waiter_slot = 4'(s);
              o.waiter_state = apca_pkg::WS_QUEUED;
              break;
            end
          end
        end
      end
      apca_pkg::KIND_POLL, apca_pkg::KIND_ABANDON: begin
        if (!used_tbl[q.slot]) o.status = apca_pkg::ST_INVALID;
        else begin
          st = wstate_tbl[q.slot];
          o.waiter_slot = q.slot;
          if (q.kind == apca_pkg::KIND_POLL) begin
            if (st == apca_pkg::WS_GRANTED) begin
              used_tbl[q.slot] = 1'b0;
              o.waiter_state = apca_pkg::WS_CLAIMED;
            end else if (st == apca_pkg::WS_QUEUED) begin
              o.waiter_state = apca_pkg::WS_QUEUED;
            end else begin
              used_tbl[q.slot] = 1'b0;
              o.status = apca_pkg::ST_ABORTED;
              o.waiter_state = apca_pkg::WS_CANCELLED;
            end
          end else begin
            wstate_tbl[q.slot] = apca_pkg::WS_CANCELLED;
            if (st == apca_pkg::WS_QUEUED) begin
              if (waiting_tbl[wres_tbl[q.slot]] > 5'd0) waiting_tbl[wres_tbl[q.slot]]--;
            end else if (st == apca_pkg::WS_GRANTED) begin
              g = release_unit(wres_tbl[q.slot], q.now_ms);
            end
            used_tbl[q.slot] = 1'b0;
            o.waiter_state = apca_pkg::WS_CANCELLED;
          end
        end
      end
      apca_pkg::KIND_RELEASE: g = release_unit(q.resource, q.now_ms);
      apca_pkg::KIND_SHUTDOWN: begin
        if (!shutting) begin
          shutting = 1'b1;
          for (int s = 0; s < apca_pkg::NUM_SLOTS; s++)
            if (used_tbl[s] && wstate_tbl[s] == apca_pkg::WS_QUEUED)
              wstate_tbl[s] = apca_pkg::WS_CANCELLED;
          for (int r = 0; r < apca_pkg::NUM_RES; r++) waiting_tbl[r] = '0;
        end
      end
      default: o.status = apca_pkg::ST_INVALID;
    endcase
    if (g >= 0) begin
      o.grant_valid = 1'b1;
      o.grant_slot = 4'(g);
    end
    return o;
  endfunction

  function automatic int idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic send_req(apca_pkg::req_t q);
    int n;
    n = idle_gap();
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_resp.insert(pending_resp.size(), arbitrate(q));
    req_count++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic apca_pkg::req_t make_req(int k, int r, int s, int c, int mp,
                                              int p, int w);
    apca_pkg::req_t q;
    q.kind = 3'(k); q.resource = 4'(r); q.slot = 4'(s); q.capacity = 8'(c);
    q.pend_limit = 17'(mp); q.priority_req = 8'(p); q.weight = 8'(w);
    q.now_ms = clock_ms;
    return q;
  endfunction

  // resp stall generator
  initial begin
    resp_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 19) == 0) resp_stall <= 1'b1;
      else if ($urandom_range(0, 2) == 0) resp_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && resp_valid && !resp_stall) begin
      apca_pkg::resp_t e;
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", resp);
      end else begin
        e = pending_resp.pop_front();
        resp_count++;
        if (resp.grant_valid) grant_count++;
        if (resp.status !== e.status || resp.waiter_slot !== e.waiter_slot ||
            resp.waiter_state !== e.waiter_state || resp.grant_valid !== e.grant_valid ||
            resp.grant_slot !== e.grant_slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d ws=%0d wst=%0d gv=%0d gs=%0d,",
                      " got st=%0d ws=%0d wst=%0d gv=%0d gs=%0d"},
                     e.status, e.waiter_slot, e.waiter_state, e.grant_valid,
                     e.grant_slot, resp.status, resp.waiter_slot, resp.waiter_state,
                     resp.grant_valid, resp.grant_slot);
        end
      end
    end
  end

  task automatic test_directed();
    // invalid forms
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 0, 0, 0, 1, 0, 0));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 0, 0, 2, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 0, 0, 2, 17'h1FFFF, 0, 0));
    send_req(make_req(apca_pkg::KIND_POLL, 0, 15, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_RELEASE, 15, 0, 0, 0, 0, 0));
    send_req(make_req(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0));
    // capacity one, two waiters with aging
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 15, 0, 1, apca_pkg::PEND_LIMIT_MAX,
                      8'hFF, 8'hFF));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 15, 0, 2, 1, 0, 0));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 15, 0, 1, apca_pkg::PEND_LIMIT_MAX, 10, 0));
    clock_ms = 32'd5000;
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 15, 0, 1, 2, 20, 1));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 15, 0, 1, 2, 0, 0));
    send_req(make_req(apca_pkg::KIND_POLL, 0, 0, 0, 0, 0, 0));
    clock_ms = 32'hFFFF_FFFF;
    send_req(make_req(apca_pkg::KIND_RELEASE, 15, 0, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_POLL, 0, 0, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_ABANDON, 0, 1, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_ABANDON, 0, 1, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 3, 0, 8'hFF, 1, 0, 0));
    drain();
  endtask

  task automatic test_shutdown();
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 4, 0, 1, 4, 1, 1));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 4, 0, 1, 4, 1, 1));
    send_req(make_req(apca_pkg::KIND_SHUTDOWN, 0, 0, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_SHUTDOWN, 0, 0, 0, 0, 0, 0));
    send_req(make_req(apca_pkg::KIND_ENQUEUE, 4, 0, 1, 4, 1, 1));
    send_req(make_req(apca_pkg::KIND_RELEASE, 4, 0, 0, 0, 0, 0));
    for (int s = 0; s < 4; s++) send_req(make_req(apca_pkg::KIND_POLL, 0, s, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int count);
    apca_pkg::req_t q;
    logic [95:0] raw;
    for (int i = 0; i < count; i++) begin
      clock_ms += $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3000);
      raw = {$urandom, $urandom, $urandom};
      q = raw[$bits(apca_pkg::req_t)-1:0];
      q.now_ms = clock_ms;
      if ($urandom_range(0, 9) != 0) begin
        q.kind = 3'($urandom_range(0, 3));
        q.resource = 4'($urandom_range(0, 3));
        q.capacity = 8'(q.resource + 4'd1);
        q.pend_limit = 17'($urandom_range(1, 8));
        if ($urandom_range(0, 30) == 0) q.pend_limit = apca_pkg::PEND_LIMIT_MAX;
        q.slot = 4'($urandom_range(0, 15));
      end else if (q.kind == apca_pkg::KIND_SHUTDOWN) begin
        q.kind = apca_pkg::KIND_RELEASE;
      end
      if (i == count / 2) drain();
      send_req(q);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mismatches = 0;
    resp_count = 0;
    grant_count = 0;
    req_count = 0;
    clock_ms = '0;
    for (int r = 0; r < apca_pkg::NUM_RES; r++) begin
      cap_tbl[r] = '0; active_tbl[r] = '0; waiting_tbl[r] = '0;
    end
    for (int s = 0; s < apca_pkg::NUM_SLOTS; s++) begin
      used_tbl[s] = 1'b0; wstate_tbl[s] = '0; wres_tbl[s] = '0; wprio_tbl[s] = '0;
      wweight_tbl[s] = '0; wseq_tbl[s] = '0; wsubmit_tbl[s] = '0;
    end
    seq_next = 64'd1;
    shutting = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1150);
    test_shutdown();
    $display("%0d requests sent, %0d results checked, %0d waiter grants seen",
             req_count, resp_count, grant_count);
    $display("covered invalid forms, aging ties, random traffic and shutdown");
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
